// ===== rtl/amge_pkg.sv =====
`timescale 1ns / 1ps
package amge_pkg;

	localparam int VERTEX_LIMIT = 16;
	localparam int MAX_LISTED   = 16;

	localparam logic [4:0] RST_VERTEX_COUNT = 5'd16;
	localparam logic       RST_DIRECTED     = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_DIRECTED     = 1'b1;

	localparam logic [3:0] FN_ADD        = 4'd0;
	localparam logic [3:0] FN_REMOVE     = 4'd1;
	localparam logic [3:0] FN_TEST       = 4'd2;
	localparam logic [3:0] FN_MARK       = 4'd3;
	localparam logic [3:0] FN_UNMARK     = 4'd4;
	localparam logic [3:0] FN_REMOVE_ALL = 4'd5;
	localparam logic [3:0] FN_DEGREE     = 4'd6;
	localparam logic [3:0] FN_MARK_ALL   = 4'd7;
	localparam logic [3:0] FN_UNMARK_ALL = 4'd8;
	localparam logic [3:0] FN_LIST       = 4'd9;
	localparam logic [3:0] FN_WALK       = 4'd10;

	localparam logic [1:0] ENTRY_NONE   = 2'd0;
	localparam logic [1:0] ENTRY_PLAIN  = 2'd1;
	localparam logic [1:0] ENTRY_MARKED = 2'd2;

	typedef struct packed {
		logic [3:0] func;
		logic [3:0] vertex_a;
		logic [3:0] vertex_b;
		logic       direction;
	} in_t;

	typedef struct packed {
		logic        status;
		logic [4:0]  answer;
		logic        is_vertex;
		logic [15:0] edge_total;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [4:0] vertex_count;
		logic       directed_mode;
	} cfg_t;

endpackage

// ===== rtl/adjacency_matrix_graph_engine.sv =====
`timescale 1ns / 1ps
// Adjacency matrix graph engine.
// Requests enter on in_valid/in_ready with an in_t payload (func, vertex_a,
// vertex_b, direction); results leave on out_valid/out_ready as out_t. Each
// request yields one result, or for list and walk one result per vertex and a
// closing result with last set. in_ready is high only while the sequencer is
// idle, so one request is in work at a time; the next request can be taken in
// the cycle after the closing result is loaded into the output register.
// Row and column requests read and evaluate one matrix entry at a time
// through the single matrix RAM port, with one more write step for each
// mirrored entry an undirected remove all clears; the walk is a depth-first
// search that keeps its path on the stack RAM.
// The user must set vertex_count and directed_mode through the APB port only
// while idle; the block itself does not enforce it. After reset the matrix
// RAM is cleared one entry per cycle, all MaxVertices squared entries (256 by
// default), and no request is taken until it is done. A stalled receiver holds
// the single output register; the sequencer waits on it and loses nothing.
module adjacency_matrix_graph_engine #(
	parameter int MaxVertices = amge_pkg::VERTEX_LIMIT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           in_valid,
	output logic           in_ready,
	input  amge_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output amge_pkg::out_t out_data
);

	localparam int VW = $clog2(MaxVertices);
	localparam int AW = $clog2(MaxVertices * MaxVertices);

	amge_pkg::cfg_t cfg;
	logic           mtx_we, mtx_re, stk_we, stk_re;
	logic [AW-1:0]  mtx_waddr, mtx_raddr;
	logic [1:0]     mtx_wdata, mtx_rdata;
	logic [VW-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	amge_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	amge_ram #(.Width(2), .Depth(MaxVertices * MaxVertices)) u_matrix (
		.clk   (clk),
		.we    (mtx_we),
		.waddr (mtx_waddr),
		.wdata (mtx_wdata),
		.re    (mtx_re),
		.raddr (mtx_raddr),
		.rdata (mtx_rdata)
	);

	amge_ram #(.Width(VW), .Depth(MaxVertices)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	amge_seq #(.MaxVertices(MaxVertices)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mtx_we    (mtx_we),
		.mtx_waddr (mtx_waddr),
		.mtx_wdata (mtx_wdata),
		.mtx_re    (mtx_re),
		.mtx_raddr (mtx_raddr),
		.mtx_rdata (mtx_rdata),
		.stk_we    (stk_we),
		.stk_waddr (stk_waddr),
		.stk_wdata (stk_wdata),
		.stk_re    (stk_re),
		.stk_raddr (stk_raddr),
		.stk_rdata (stk_rdata)
	);

endmodule

// ===== rtl/amge_ram.sv =====
`timescale 1ns / 1ps
module amge_ram #(
	parameter int Width = 2,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/amge_cfg.sv =====
`timescale 1ns / 1ps
module amge_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output amge_pkg::cfg_t      cfg
);

	logic [4:0] vertex_count_q;
	logic       directed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= amge_pkg::RST_VERTEX_COUNT;
			directed_q     <= amge_pkg::RST_DIRECTED;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				amge_pkg::REG_VERTEX_COUNT: vertex_count_q <= pwdata[4:0];
				amge_pkg::REG_DIRECTED:     directed_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			amge_pkg::REG_VERTEX_COUNT: prdata = {27'd0, vertex_count_q};
			amge_pkg::REG_DIRECTED:     prdata = {31'd0, directed_q};
			default:                    prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg.vertex_count  = vertex_count_q;
	assign cfg.directed_mode = directed_q;

endmodule

// ===== rtl/amge_seq.sv =====
`timescale 1ns / 1ps
module amge_seq #(
	parameter int MaxVertices = amge_pkg::VERTEX_LIMIT,
	localparam int VW = $clog2(MaxVertices),
	localparam int NW = $clog2(MaxVertices + 1),
	localparam int AW = $clog2(MaxVertices * MaxVertices)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amge_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  amge_pkg::in_t        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output amge_pkg::out_t       out_data,
	output logic                 mtx_we,
	output logic [AW-1:0]        mtx_waddr,
	output logic [1:0]           mtx_wdata,
	output logic                 mtx_re,
	output logic [AW-1:0]        mtx_raddr,
	input  logic [1:0]           mtx_rdata,
	output logic                 stk_we,
	output logic [VW-1:0]        stk_waddr,
	output logic [VW-1:0]        stk_wdata,
	output logic                 stk_re,
	output logic [VW-1:0]        stk_raddr,
	input  logic [VW-1:0]        stk_rdata
);

	typedef enum logic [12:0] {
		S_CLEAR      = 13'b0000000000001,
		S_IDLE       = 13'b0000000000010,
		S_DECODE     = 13'b0000000000100,
		S_MIRROR     = 13'b0000000001000,
		S_SINGLE_EV  = 13'b0000000010000,
		S_SCAN_RD    = 13'b0000000100000,
		S_SCAN_EV    = 13'b0000001000000,
		S_SCAN_MIR   = 13'b0000010000000,
		S_WALK_START = 13'b0000100000000,
		S_WALK_RD    = 13'b0001000000000,
		S_WALK_EV    = 13'b0010000000000,
		S_WALK_POP   = 13'b0100000000000,
		S_DONE       = 13'b1000000000000
	} state_t;

	localparam logic [AW-1:0] ClearLast = AW'(MaxVertices * MaxVertices - 1);
	localparam int MAX_LISTED_C = amge_pkg::MAX_LISTED;

	state_t           state_q, state_d;
	logic [3:0]       func_q, func_d;
	logic [VW-1:0]    a_q, a_d, b_q, b_d, cur_q, cur_d;
	logic             dir_q, dir_d, err_q, err_d;
	logic [4:0]       cnt_q, cnt_d, k_q, k_d;
	logic [NW-1:0]    i_q, i_d, depth_q, depth_d;
	logic [MaxVertices-1:0] vis_q, vis_d;
	logic [15:0]      edges_q, edges_d;
	logic [AW-1:0]    clr_q, clr_d;
	amge_pkg::out_t   out_q, out_d;
	logic             out_valid_q, out_valid_d;

	logic [NW-1:0]    n;
	logic             slot_free;
	logic             bad;
	logic [AW-1:0]    scan_addr, mirror_addr;
	logic             hit;

	function automatic logic [AW-1:0] cell_addr(logic [VW-1:0] r, logic [VW-1:0] c);
		return AW'(32'(r) * MaxVertices + 32'(c));
	endfunction

	always_comb begin
		if (32'(cfg.vertex_count) > 32'(MaxVertices)) begin
			n = NW'(MaxVertices);
		end else begin
			n = NW'(cfg.vertex_count);
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign bad = (in_data.func <= amge_pkg::FN_WALK) &&
		((32'(in_data.vertex_a) >= 32'(n)) ||
		 ((in_data.func <= amge_pkg::FN_UNMARK) && (32'(in_data.vertex_b) >= 32'(n))) ||
		 ((in_data.func == amge_pkg::FN_WALK) && !cfg.directed_mode));

	assign scan_addr   = dir_q ? cell_addr(VW'(i_q), a_q) : cell_addr(a_q, VW'(i_q));
	assign mirror_addr = dir_q ? cell_addr(a_q, VW'(i_q)) : cell_addr(VW'(i_q), a_q);
	assign hit = (mtx_rdata == amge_pkg::ENTRY_PLAIN) && !vis_q[VW'(i_q)];

	always_comb begin
		state_d     = state_q;
		func_d      = func_q;
		a_d         = a_q;
		b_d         = b_q;
		cur_d       = cur_q;
		dir_d       = dir_q;
		err_d       = err_q;
		cnt_d       = cnt_q;
		k_d         = k_q;
		i_d         = i_q;
		depth_d     = depth_q;
		vis_d       = vis_q;
		edges_d     = edges_q;
		clr_d       = clr_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;
		mtx_we      = 1'b0;
		mtx_waddr   = scan_addr;
		mtx_wdata   = amge_pkg::ENTRY_NONE;
		mtx_re      = 1'b0;
		mtx_raddr   = scan_addr;
		stk_we      = 1'b0;
		stk_waddr   = VW'(depth_q);
		stk_wdata   = VW'(i_q);
		stk_re      = 1'b0;
		stk_raddr   = VW'(depth_q - NW'(2));

		unique case (state_q)
			S_CLEAR: begin
				mtx_we    = 1'b1;
				mtx_waddr = clr_q;
				clr_d     = clr_q + AW'(1);
				if (clr_q == ClearLast) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					func_d  = in_data.func;
					a_d     = VW'(in_data.vertex_a);
					b_d     = VW'(in_data.vertex_b);
					dir_d   = in_data.direction;
					err_d   = bad;
					cnt_d   = '0;
					k_d     = '0;
					i_d     = '0;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				mtx_waddr = cell_addr(a_q, b_q);
				mtx_raddr = cell_addr(a_q, b_q);
				if (err_q || func_q > amge_pkg::FN_WALK) begin
					state_d = S_DONE;
				end else begin
					unique case (func_q)
						amge_pkg::FN_ADD, amge_pkg::FN_REMOVE: begin
							mtx_we    = 1'b1;
							mtx_wdata = (func_q == amge_pkg::FN_ADD) ?
								amge_pkg::ENTRY_PLAIN : amge_pkg::ENTRY_NONE;
							edges_d   = (func_q == amge_pkg::FN_ADD) ?
								edges_q + 16'd1 : edges_q - 16'd1;
							state_d   = cfg.directed_mode ? S_DONE : S_MIRROR;
						end
						amge_pkg::FN_TEST, amge_pkg::FN_MARK, amge_pkg::FN_UNMARK: begin
							mtx_re  = 1'b1;
							state_d = S_SINGLE_EV;
						end
						amge_pkg::FN_WALK: state_d = S_WALK_START;
						default:           state_d = S_SCAN_RD;
					endcase
				end
			end
			S_MIRROR: begin
				mtx_we    = 1'b1;
				mtx_waddr = cell_addr(b_q, a_q);
				mtx_wdata = (func_q == amge_pkg::FN_ADD) ?
					amge_pkg::ENTRY_PLAIN : amge_pkg::ENTRY_NONE;
				state_d   = S_DONE;
			end
			S_SINGLE_EV: begin
				mtx_waddr = cell_addr(a_q, b_q);
				state_d   = S_DONE;
				if (func_q == amge_pkg::FN_TEST) begin
					cnt_d = (mtx_rdata == amge_pkg::ENTRY_PLAIN) ? 5'd1 : 5'd0;
				end else if (func_q == amge_pkg::FN_MARK) begin
					mtx_we    = (mtx_rdata == amge_pkg::ENTRY_PLAIN);
					mtx_wdata = amge_pkg::ENTRY_MARKED;
				end else begin
					mtx_we    = (mtx_rdata == amge_pkg::ENTRY_MARKED);
					mtx_wdata = amge_pkg::ENTRY_PLAIN;
				end
			end
			S_SCAN_RD: begin
				if (i_q == n || (func_q == amge_pkg::FN_LIST && 32'(k_q) == MAX_LISTED_C)) begin
					state_d = S_DONE;
				end else begin
					mtx_re  = 1'b1;
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				i_d     = i_q + NW'(1);
				state_d = S_SCAN_RD;
				unique case (func_q)
					amge_pkg::FN_REMOVE_ALL: begin
						if (mtx_rdata == amge_pkg::ENTRY_PLAIN) begin
							mtx_we  = 1'b1;
							edges_d = edges_q - 16'd1;
							cnt_d   = cnt_q + 5'd1;
							if (!cfg.directed_mode) begin
								i_d     = i_q;
								state_d = S_SCAN_MIR;
							end
						end
					end
					amge_pkg::FN_DEGREE: begin
						if (mtx_rdata == amge_pkg::ENTRY_PLAIN) begin
							cnt_d = cnt_q + 5'd1;
						end
					end
					amge_pkg::FN_MARK_ALL: begin
						if (mtx_rdata == amge_pkg::ENTRY_PLAIN) begin
							mtx_we    = 1'b1;
							mtx_wdata = amge_pkg::ENTRY_MARKED;
							cnt_d     = cnt_q + 5'd1;
						end
					end
					amge_pkg::FN_UNMARK_ALL: begin
						if (mtx_rdata == amge_pkg::ENTRY_MARKED) begin
							mtx_we    = 1'b1;
							mtx_wdata = amge_pkg::ENTRY_PLAIN;
							cnt_d     = cnt_q + 5'd1;
						end
					end
					default: begin
						if (mtx_rdata == amge_pkg::ENTRY_PLAIN) begin
							if (slot_free) begin
								out_valid_d        = 1'b1;
								out_d.status       = 1'b0;
								out_d.answer       = 5'(i_q);
								out_d.is_vertex    = 1'b1;
								out_d.edge_total   = edges_q;
								out_d.last         = 1'b0;
								k_d                = k_q + 5'd1;
								cnt_d              = cnt_q + 5'd1;
							end else begin
								// hold until the output slot frees up
								i_d     = i_q;
								state_d = S_SCAN_EV;
							end
						end
					end
				endcase
			end
			S_SCAN_MIR: begin
				mtx_we    = 1'b1;
				mtx_waddr = mirror_addr;
				i_d       = i_q + NW'(1);
				state_d   = S_SCAN_RD;
			end
			S_WALK_START: begin
				if (slot_free) begin
					out_valid_d      = 1'b1;
					out_d.status     = 1'b0;
					out_d.answer     = 5'(a_q);
					out_d.is_vertex  = 1'b1;
					out_d.edge_total = edges_q;
					out_d.last       = 1'b0;
					k_d              = 5'd1;
					cnt_d            = 5'd1;
					vis_d            = '0;
					vis_d[a_q]       = 1'b1;
					cur_d            = a_q;
					depth_d          = NW'(1);
					i_d              = '0;
					stk_we           = 1'b1;
					stk_waddr        = '0;
					stk_wdata        = a_q;
					state_d          = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				mtx_raddr = cell_addr(cur_q, VW'(i_q));
				if (i_q == n) begin
					if (depth_q == NW'(1)) begin
						state_d = S_DONE;
					end else begin
						// pop: parent resumes just past the child it pushed
						stk_re  = 1'b1;
						depth_d = depth_q - NW'(1);
						i_d     = NW'(cur_q) + NW'(1);
						state_d = S_WALK_POP;
					end
				end else begin
					mtx_re  = 1'b1;
					state_d = S_WALK_EV;
				end
			end
			S_WALK_EV: begin
				if (hit) begin
					if (32'(k_q) < MAX_LISTED_C && !slot_free) begin
						state_d = S_WALK_EV;
					end else begin
						if (32'(k_q) < MAX_LISTED_C) begin
							out_valid_d      = 1'b1;
							out_d.status     = 1'b0;
							out_d.answer     = 5'(i_q);
							out_d.is_vertex  = 1'b1;
							out_d.edge_total = edges_q;
							out_d.last       = 1'b0;
							k_d              = k_q + 5'd1;
						end
						vis_d[VW'(i_q)] = 1'b1;
						cnt_d           = cnt_q + 5'd1;
						stk_we          = 1'b1;
						depth_d         = depth_q + NW'(1);
						cur_d           = VW'(i_q);
						i_d             = '0;
						state_d         = S_WALK_RD;
					end
				end else begin
					i_d     = i_q + NW'(1);
					state_d = S_WALK_RD;
				end
			end
			S_WALK_POP: begin
				cur_d   = stk_rdata;
				state_d = S_WALK_RD;
			end
			S_DONE: begin
				if (slot_free) begin
					out_valid_d      = 1'b1;
					out_d.status     = err_q;
					out_d.answer     = cnt_q;
					out_d.is_vertex  = 1'b0;
					out_d.edge_total = edges_q;
					out_d.last       = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			edges_q     <= '0;
			vis_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			edges_q     <= edges_d;
			vis_q       <= vis_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		a_q     <= a_d;
		b_q     <= b_d;
		cur_q   <= cur_d;
		dir_q   <= dir_d;
		err_q   <= err_d;
		cnt_q   <= cnt_d;
		k_q     <= k_d;
		i_q     <= i_d;
		depth_q <= depth_d;
		out_q   <= out_d;
	end

endmodule

// ===== test/adjacency_matrix_graph_engine_checker.sv =====
`timescale 1ns / 1ps
module adjacency_matrix_graph_engine_checker
	import amge_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_t        in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_t       out_data,
	input  logic [4:0] vertex_count,
	input  logic       directed_mode,
	output int         fail_count,
	output int         pending,
	output int         result_count
);

	logic [1:0]  graph_matrix [VERTEX_LIMIT][VERTEX_LIMIT];
	logic [15:0] edge_tally;
	out_t        expected_results [$];

	task automatic report_mismatch(input string what, input out_t got, input out_t want);
		$display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
		fail_count++;
	endtask

	function automatic logic [1:0] entry_of(int v, int i, logic dir_in);
		return dir_in ? graph_matrix[i][v] : graph_matrix[v][i];
	endfunction

	task automatic set_entry(int v, int i, logic dir_in, logic [1:0] val);
		if (dir_in)
			graph_matrix[i][v] = val;
		else
			graph_matrix[v][i] = val;
	endtask

	task automatic push_result(logic st, int ans, logic isv, logic lst);
		out_t r;
		r.status     = st;
		r.answer     = ans[4:0];
		r.is_vertex  = isv;
		r.edge_total = edge_tally;
		r.last       = lst;
		expected_results.push_back(r);
	endtask

	// compute all results of one request and update the local copy of the graph
	task automatic predict_request(in_t req);
		int n, a, b, cnt, k, depth, v, j, w;
		logic pushed;
		logic visited [VERTEX_LIMIT];
		int stack_v [VERTEX_LIMIT];
		int stack_j [VERTEX_LIMIT];
		n   = (vertex_count > VERTEX_LIMIT) ? VERTEX_LIMIT : vertex_count;
		a   = req.vertex_a;
		b   = req.vertex_b;
		cnt = 0;
		k   = 0;
		if (req.func > FN_WALK) begin
			push_result(1'b0, 0, 1'b0, 1'b1);
			return;
		end
		if (a >= n || (req.func <= FN_UNMARK && b >= n) ||
				(req.func == FN_WALK && !directed_mode)) begin
			push_result(1'b1, 0, 1'b0, 1'b1);
			return;
		end
		case (req.func)
			FN_ADD: begin
				graph_matrix[a][b] = ENTRY_PLAIN;
				if (!directed_mode) graph_matrix[b][a] = ENTRY_PLAIN;
				edge_tally++;
			end
			FN_REMOVE: begin
				graph_matrix[a][b] = ENTRY_NONE;
				if (!directed_mode) graph_matrix[b][a] = ENTRY_NONE;
				edge_tally--;
			end
			FN_TEST: cnt = (graph_matrix[a][b] == ENTRY_PLAIN);
			FN_MARK: if (graph_matrix[a][b] == ENTRY_PLAIN) graph_matrix[a][b] = ENTRY_MARKED;
			FN_UNMARK: if (graph_matrix[a][b] == ENTRY_MARKED) graph_matrix[a][b] = ENTRY_PLAIN;
			FN_REMOVE_ALL: begin
				for (int i = 0; i < n; i++)
					if (entry_of(a, i, req.direction) == ENTRY_PLAIN) begin
						set_entry(a, i, req.direction, ENTRY_NONE);
						if (!directed_mode) set_entry(a, i, !req.direction, ENTRY_NONE);
						edge_tally--;
						cnt++;
					end
			end
			FN_DEGREE: begin
				for (int i = 0; i < n; i++)
					if (entry_of(a, i, req.direction) == ENTRY_PLAIN) cnt++;
			end
			FN_MARK_ALL: begin
				for (int i = 0; i < n; i++)
					if (entry_of(a, i, req.direction) == ENTRY_PLAIN) begin
						set_entry(a, i, req.direction, ENTRY_MARKED);
						cnt++;
					end
			end
			FN_UNMARK_ALL: begin
				for (int i = 0; i < n; i++)
					if (entry_of(a, i, req.direction) == ENTRY_MARKED) begin
						set_entry(a, i, req.direction, ENTRY_PLAIN);
						cnt++;
					end
			end
			FN_LIST: begin
				for (int i = 0; i < n && k < MAX_LISTED; i++)
					if (entry_of(a, i, req.direction) == ENTRY_PLAIN) begin
						push_result(1'b0, i, 1'b1, 1'b0);
						k++;
						cnt++;
					end
			end
			default: begin
				foreach (visited[i]) visited[i] = 1'b0;
				visited[a] = 1'b1;
				push_result(1'b0, a, 1'b1, 1'b0);
				k = 1;
				cnt = 1;
				stack_v[0] = a;
				stack_j[0] = 0;
				depth = 1;
				while (depth > 0) begin
					v = stack_v[depth-1];
					j = stack_j[depth-1];
					pushed = 1'b0;
					while (j < n && !pushed) begin
						w = j;
						j++;
						if (graph_matrix[v][w] == ENTRY_PLAIN && !visited[w]) begin
							stack_j[depth-1] = j;
							visited[w] = 1'b1;
							if (k < MAX_LISTED) begin
								push_result(1'b0, w, 1'b1, 1'b0);
								k++;
							end
							cnt++;
							if (depth < VERTEX_LIMIT) begin
								stack_v[depth] = w;
								stack_j[depth] = 0;
								depth++;
							end
							pushed = 1'b1;
						end
					end
					if (!pushed) depth--;
				end
			end
		endcase
		push_result(1'b0, cnt, 1'b0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (graph_matrix[r, c]) graph_matrix[r][c] = ENTRY_NONE;
			edge_tally = '0;
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", out_data, '0);
				end else begin
					out_t want;
					want = expected_results.pop_front();
					if (out_data.status !== want.status)
						report_mismatch("status", out_data, want);
					else if (out_data.answer !== want.answer)
						report_mismatch("answer", out_data, want);
					else if (out_data.is_vertex !== want.is_vertex)
						report_mismatch("is_vertex", out_data, want);
					else if (out_data.edge_total !== want.edge_total)
						report_mismatch("edge_total", out_data, want);
					else if (out_data.last !== want.last)
						report_mismatch("last", out_data, want);
				end
			end
			if (in_valid && in_ready) predict_request(in_data);
		end
		pending = expected_results.size();
	end

endmodule

// ===== test/adjacency_matrix_graph_engine_tb.sv =====
`timescale 1ns / 1ps
module adjacency_matrix_graph_engine_tb;
	import amge_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	in_t         in_data;
	logic        out_valid, out_ready;
	out_t        out_data;
	logic [4:0]  cfg_vertex_count;
	logic        cfg_directed;
	int          fail_count, pending, result_count;
	int          send_idle_pct, recv_idle_pct;
	int          hold_off_cycles = 0;
	logic        stall_request;
	logic        stall_done = 1'b0;
	int          idle_cycles;
	int          request_count;

	adjacency_matrix_graph_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	adjacency_matrix_graph_engine_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.vertex_count(cfg_vertex_count), .directed_mode(cfg_directed),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stalls, or one long hold-off when asked
	always @(posedge clk) begin
		if (stall_request && !stall_done) begin
			stall_done      <= 1'b1;
			hold_off_cycles <= 400;
			out_ready       <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results pending", pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drop valid, then hold until every expected result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int count, input logic directed);
		wait_drained();
		write_reg(3'd4 * REG_VERTEX_COUNT, count);
		write_reg(3'd4 * REG_DIRECTED, directed);
		cfg_vertex_count = count;
		cfg_directed     = directed;
	endtask

	// valid stays up after acceptance; the next request reloads or drops it, a drain drops it
	task automatic send_request(input logic [3:0] fn, input logic [3:0] a,
			input logic [3:0] b, input logic dir_in);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{func: fn, vertex_a: a, vertex_b: b, direction: dir_in};
		do @(posedge clk); while (!in_ready);
		request_count++;
	endtask

	// mostly in-range ids, edge-heavy mix so walks and lists find neighbors
	task automatic send_random(input int n);
		logic [3:0] fn, a, b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) fn = FN_ADD;
		else if (pick < 90) fn = $urandom_range(FN_WALK, FN_REMOVE);
		else fn = $urandom_range(15);
		if ($urandom_range(9) == 0 || n == 0) begin
			a = $urandom_range(15);
			b = $urandom_range(15);
		end else begin
			a = $urandom_range(n - 1);
			b = $urandom_range(n - 1);
		end
		send_request(fn, a, b, $urandom_range(1));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
		stall_request = 1'b0; idle_cycles = 0; request_count = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		cfg_vertex_count = RST_VERTEX_COUNT;
		cfg_directed     = RST_DIRECTED;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed checks at reset configuration, full size
		send_request(FN_ADD, 0, 15, 0);
		send_request(FN_ADD, 15, 0, 0);
		send_request(FN_ADD, 0, 5, 0);
		send_request(FN_ADD, 5, 10, 0);
		send_request(FN_TEST, 0, 15, 0);
		send_request(FN_MARK, 0, 5, 0);
		send_request(FN_TEST, 0, 5, 0);
		send_request(FN_WALK, 0, 0, 0);
		send_request(FN_UNMARK, 0, 5, 0);
		send_request(FN_WALK, 0, 0, 1);
		send_request(FN_DEGREE, 0, 0, 0);
		send_request(FN_DEGREE, 0, 0, 1);
		send_request(FN_LIST, 0, 0, 0);
		send_request(FN_MARK_ALL, 0, 0, 0);
		send_request(FN_UNMARK_ALL, 0, 0, 0);
		send_request(FN_REMOVE_ALL, 0, 0, 1);
		send_request(FN_REMOVE, 3, 4, 0);
		send_request(4'd11, 15, 15, 1);
		send_request(4'd15, 0, 0, 0);
		// vertex out of range and walk on an undirected graph
		configure(4, 1'b0);
		send_request(FN_ADD, 4, 0, 0);
		send_request(FN_TEST, 1, 15, 0);
		send_request(FN_ADD, 1, 2, 0);
		send_request(FN_LIST, 2, 0, 1);
		send_request(FN_WALK, 1, 0, 0);
		send_request(FN_REMOVE_ALL, 1, 0, 0);
		configure(0, 1'b1);
		send_request(FN_ADD, 0, 0, 0);
		send_request(FN_DEGREE, 0, 0, 0);

		// random phases over several settings
		configure(16, 1'b1);
		send_idle_pct = 36; recv_idle_pct = 52;
		repeat (70) send_random(16);
		// full graph drives a long walk
		for (int i = 0; i < 16; i++)
			send_request(FN_ADD, i, (i * 7 + 3) % 16, 0);
		send_request(FN_WALK, 0, 0, 0);
		configure(1, 1'b0);
		repeat (15) send_random(1);
		configure(6, 1'b0);
		send_idle_pct = 52; recv_idle_pct = 36;
		repeat (60) send_random(6);
		configure(9, 1'b1);
		repeat (50) send_random(9);
		configure(31, 1'b1);
		send_idle_pct = 0; recv_idle_pct = 0;
		stall_request = 1'b1;
		repeat (20) send_random(16);
		wait_drained();
		repeat (80) send_random(16);

		wait_drained();
		$display("sent %0d requests, checked %0d results", request_count, result_count);
		$display("covered all functions, range errors and several vertex counts from 0 to 31");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
